// File: hdl/lss_pkg.sv
`timescale 1ns / 1ps

package lss_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int POS_W         = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DUMP   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_DUMP
    } state_t;

    typedef enum logic [1:0] {
        ADDR_TOP,
        ADDR_BOTTOM,
        ADDR_PREV,
        ADDR_NEXT
    } addr_sel_t;

    typedef enum logic [1:0] {
        EMIT_STATUS,
        EMIT_POP,
        EMIT_FOUND,
        EMIT_DUMP
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      push_write;
        logic      pop;
        logic      rd_en;
        addr_sel_t addr_sel;
        logic      emit;
        emit_sel_t emit_sel;
        status_t   code;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  full;
        logic  match;
        logic  idx_zero;
        logic  idx_last;
        logic  out_free;
    } sts_t;

endpackage

// File: hdl/lss_if.sv
`timescale 1ns / 1ps

interface lss_in_if;
    logic                             valid;
    logic                             ready;
    logic [lss_pkg::KIND_W-1:0]       kind;
    logic signed [lss_pkg::DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface lss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lss_pkg::DATA_W-1:0]  data;
    logic [lss_pkg::STATUS_W-1:0]       status;
    logic [lss_pkg::POS_W-1:0]          position;
    logic                               last;

    modport source (output valid, output data, output status, output position,
                    output last, input ready);
    modport sink (input valid, input data, input status, input position,
                  input last, output ready);
endinterface

// File: hdl/lss_ctrl.sv
`timescale 1ns / 1ps

module lss_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid,
    output logic          ready,
    input  lss_pkg::sts_t sts,
    output lss_pkg::cmd_t cmd
);

    lss_pkg::state_t state_reg;
    lss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lss_pkg::S_IDLE:
            begin
                if (valid)
                begin
                    state_next = lss_pkg::S_EXEC;
                end
            end
            lss_pkg::S_EXEC:
            begin
                if (sts.kind == lss_pkg::KIND_PUSH || sts.empty)
                begin
                    if (sts.out_free)
                    begin
                        state_next = lss_pkg::S_IDLE;
                    end
                end
                else
                begin
                    unique case (sts.kind)
                        lss_pkg::KIND_POP:    state_next = lss_pkg::S_POP;
                        lss_pkg::KIND_SEARCH: state_next = lss_pkg::S_SCAN;
                        default:              state_next = lss_pkg::S_DUMP;
                    endcase
                end
            end
            lss_pkg::S_POP:
            begin
                if (sts.out_free)
                begin
                    state_next = lss_pkg::S_IDLE;
                end
            end
            lss_pkg::S_SCAN:
            begin
                if ((sts.match || sts.idx_zero) && sts.out_free)
                begin
                    state_next = lss_pkg::S_IDLE;
                end
            end
            lss_pkg::S_DUMP:
            begin
                if (sts.idx_last && sts.out_free)
                begin
                    state_next = lss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready        = 1'b0;
        cmd.load     = 1'b0;
        cmd.push_write = 1'b0;
        cmd.pop      = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.addr_sel = lss_pkg::ADDR_TOP;
        cmd.emit     = 1'b0;
        cmd.emit_sel = lss_pkg::EMIT_STATUS;
        cmd.code     = lss_pkg::ST_OK;
        unique case (state_reg)
            lss_pkg::S_IDLE:
            begin
                ready    = 1'b1;
                cmd.load = valid;
            end
            lss_pkg::S_EXEC:
            begin
                if (sts.kind == lss_pkg::KIND_PUSH)
                begin
                    cmd.emit       = sts.out_free;
                    cmd.push_write = sts.out_free && !sts.full;
                    cmd.code       = sts.full ? lss_pkg::ST_FULL : lss_pkg::ST_OK;
                end
                else if (sts.empty)
                begin
                    cmd.emit = sts.out_free;
                    cmd.code = lss_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = (sts.kind == lss_pkg::KIND_DUMP) ?
                                   lss_pkg::ADDR_BOTTOM : lss_pkg::ADDR_TOP;
                end
            end
            lss_pkg::S_POP:
            begin
                cmd.emit     = sts.out_free;
                cmd.pop      = sts.out_free;
                cmd.emit_sel = lss_pkg::EMIT_POP;
            end
            lss_pkg::S_SCAN:
            begin
                if (sts.match)
                begin
                    cmd.emit     = sts.out_free;
                    cmd.emit_sel = lss_pkg::EMIT_FOUND;
                end
                else if (sts.idx_zero)
                begin
                    cmd.emit = sts.out_free;
                    cmd.code = lss_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = lss_pkg::ADDR_PREV;
                end
            end
            lss_pkg::S_DUMP:
            begin
                cmd.emit     = sts.out_free;
                cmd.emit_sel = lss_pkg::EMIT_DUMP;
                cmd.rd_en    = sts.out_free && !sts.idx_last;
                cmd.addr_sel = lss_pkg::ADDR_NEXT;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/lss_dp.sv
`timescale 1ns / 1ps

module lss_dp
#(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lss_pkg::cmd_t                       cmd,
    output lss_pkg::sts_t                       sts,
    input  logic [lss_pkg::KIND_W-1:0]          kind,
    input  logic signed [lss_pkg::DATA_W-1:0]   value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic signed [lss_pkg::DATA_W-1:0]   data,
    output logic [lss_pkg::STATUS_W-1:0]        status,
    output logic [lss_pkg::POS_W-1:0]           position,
    output logic                                last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic signed [lss_pkg::DATA_W-1:0] mem_reg [DEPTH];
    logic signed [lss_pkg::DATA_W-1:0] rd_data_reg;
    logic signed [lss_pkg::DATA_W-1:0] value_reg;
    lss_pkg::kind_t                    kind_reg;
    logic [FW-1:0]                     fill_reg;
    logic [FW-1:0]                     fill_next;
    logic [AW-1:0]                     idx_reg;
    logic [AW-1:0]                     rd_addr;
    logic [FW-1:0]                     idx_ext;
    logic [FW-1:0]                     fill_dec;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [lss_pkg::DATA_W-1:0] out_data_reg;
    logic [lss_pkg::STATUS_W-1:0]      out_status_reg;
    logic [lss_pkg::POS_W-1:0]         out_pos_reg;
    logic                              out_last_reg;

    function automatic logic [lss_pkg::POS_W-1:0] POS_CALC(input logic [FW-1:0] d);
        logic [FW+lss_pkg::POS_W-1:0] wide;
        wide     = (FW + lss_pkg::POS_W)'(d);
        POS_CALC = wide[lss_pkg::POS_W-1:0];
    endfunction

    assign idx_ext  = FW'(idx_reg);
    assign fill_dec = fill_reg - FW'(1);

    always_comb
    begin
        case (cmd.addr_sel)
            lss_pkg::ADDR_TOP:    rd_addr = fill_dec[AW-1:0];
            lss_pkg::ADDR_BOTTOM: rd_addr = '0;
            lss_pkg::ADDR_PREV:   rd_addr = idx_reg - AW'(1);
            default:              rd_addr = idx_reg + AW'(1);
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.push_write)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_dec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_write)
        begin
            mem_reg[fill_reg[AW-1:0]] <= value_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
            idx_reg     <= rd_addr;
        end
        if (cmd.load)
        begin
            kind_reg  <= lss_pkg::kind_t'(kind);
            value_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid_next = cmd.emit || (out_valid_reg && !res_ready);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg   <= (cmd.emit_sel == lss_pkg::EMIT_POP ||
                               cmd.emit_sel == lss_pkg::EMIT_DUMP) ? rd_data_reg : '0;
            out_status_reg <= (cmd.emit_sel == lss_pkg::EMIT_STATUS) ?
                              cmd.code : lss_pkg::ST_OK;
            out_pos_reg    <= (cmd.emit_sel == lss_pkg::EMIT_FOUND) ?
                              POS_CALC(fill_reg - idx_ext) : '0;
            out_last_reg   <= (cmd.emit_sel == lss_pkg::EMIT_DUMP) ? sts.idx_last : 1'b1;
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.empty    = (fill_reg == '0);
    assign sts.full     = (fill_reg == FW'(DEPTH));
    assign sts.match    = (rd_data_reg == value_reg);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_last = (idx_ext == fill_dec);
    assign sts.out_free = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign status    = out_status_reg;
    assign position  = out_pos_reg;
    assign last      = out_last_reg;

endmodule

// File: hdl/lifo_stack_with_search_top.sv
`timescale 1ns / 1ps

// Bounded stack of DEPTH signed 32-bit words with push, pop, search and dump,
// one operation per word on the item channel and one or more words on the
// result channel, the final one of each operation marked by last. Operations
// are handled one at a time through a single-port entry memory with a
// registered read; search compares entries from the top down and dump
// reads every held entry from the bottom up. A result register lets a new
// operation be taken while the previous result still waits, and a stalled
// result channel holds the operation in progress. The entries need no
// clearing after reset.
module lifo_stack_with_search_top
#(
    parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
)
(
    input logic       clk,
    input logic       rst_n,
    lss_in_if.sink    item,
    lss_out_if.source result
);

    lss_pkg::cmd_t cmd;
    lss_pkg::sts_t sts;

    lss_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (item.valid),
        .ready (item.ready),
        .sts   (sts),
        .cmd   (cmd)
    );

    lss_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .kind      (item.kind),
        .value     (item.value),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .data      (result.data),
        .status    (result.status),
        .position  (result.position),
        .last      (result.last)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("Result emitted while the result register is occupied.");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_write |-> !sts.full)
        else $error("Write into a full stack.");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.empty)
        else $error("Pop from an empty stack.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("New word taken while an operation is in progress.");

endmodule

// File: bench/lifo_stack_with_search_top_tb.sv
`timescale 1ns / 1ps

module lifo_stack_with_search_top_tb;

    import lss_pkg::*;

    localparam int STACK_DEPTH    = 8;
    localparam int RANDOM_OPS     = 125;
    localparam int STALL_LIMIT    = 1000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int HOLDOFF_AFTER  = 40;
    localparam int QUIET_FROM     = 300;
    localparam int QUIET_TO       = 600;
    localparam int DRAIN_CYCLES   = 30;

    typedef struct {
        kind_t              kind;
        logic signed [31:0] value;
    } stack_op_t;

    typedef struct packed {
        logic signed [31:0] data;
        status_t            status;
        logic [3:0]         position;
        logic               last;
    } stack_word_t;

    logic clk;
    logic rst_n;

    lss_in_if  item_bus ();
    lss_out_if result_bus ();

    lifo_stack_with_search_top #(
        .DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus.sink),
        .result (result_bus.source)
    );

    stack_op_t   pending_ops[$];
    stack_word_t expected_words[$];

    logic signed [31:0] held_words[STACK_DEPTH];
    int                 held_count;

    logic item_fire;
    int   cycle_count;
    int   words_seen;
    int   mismatch_count;
    int   quiet_cycles;
    int   holdoff_left;
    logic holdoff_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic take_idle();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
        begin
            return 1'b0;
        end
        return ($urandom_range(0, 99) < 32);
    endfunction

    task automatic add_op(input kind_t kind, input logic signed [31:0] value);
        stack_op_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    task automatic predict_stack_op(input kind_t kind, input logic signed [31:0] value);
        stack_word_t w;
        int          i;
        logic        found;
        w.data     = '0;
        w.status   = ST_OK;
        w.position = '0;
        w.last     = 1'b1;
        found      = 1'b0;
        case (kind)
            KIND_PUSH:
            begin
                if (held_count >= STACK_DEPTH)
                begin
                    w.status = ST_FULL;
                end
                else
                begin
                    held_words[held_count] = value;
                    held_count++;
                end
                expected_words.push_back(w);
            end
            KIND_POP:
            begin
                if (held_count == 0)
                begin
                    w.status = ST_EMPTY;
                end
                else
                begin
                    held_count--;
                    w.data = held_words[held_count];
                end
                expected_words.push_back(w);
            end
            KIND_SEARCH:
            begin
                if (held_count == 0)
                begin
                    w.status = ST_EMPTY;
                end
                else
                begin
                    for (i = held_count; i > 0 && !found; i--)
                    begin
                        if (held_words[i - 1] == value)
                        begin
                            found      = 1'b1;
                            w.position = 4'(held_count - i + 1);
                        end
                    end
                    if (!found)
                    begin
                        w.status = ST_NOTFOUND;
                    end
                end
                expected_words.push_back(w);
            end
            default:
            begin
                if (held_count == 0)
                begin
                    w.status = ST_EMPTY;
                    expected_words.push_back(w);
                end
                else
                begin
                    for (i = 0; i < held_count; i++)
                    begin
                        w.data = held_words[i];
                        w.last = (i + 1 == held_count);
                        expected_words.push_back(w);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        stack_word_t want;
        stack_word_t got;
        string       want_text;
        string       got_text;
        cycle_count <= cycle_count + 1;
        item_fire   <= item_bus.valid && item_bus.ready;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.data     = result_bus.data;
                got.status   = status_t'(result_bus.status);
                got.position = result_bus.position;
                got.last     = result_bus.last;
                got_text     = $sformatf("data=%0d status=%0d pos=%0d last=%0b",
                                         got.data, got.status, got.position, got.last);
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, actual %s",
                             $time, got_text);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        want_text = $sformatf("data=%0d status=%0d pos=%0d last=%0b",
                                              want.data, want.status, want.position,
                                              want.last);
                        $display("%0t: expected %s, actual %s", $time, want_text, got_text);
                    end
                end
            end
            if (item_bus.valid && item_bus.ready)
            begin
                predict_stack_op(kind_t'(item_bus.kind), item_bus.value);
            end
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_fire)
            begin
                pending_ops.delete(0);
            end
            if (!item_bus.valid || item_fire)
            begin
                if (pending_ops.size() != 0 && !take_idle())
                begin
                    item_bus.valid <= 1'b1;
                    item_bus.kind  <= pending_ops[0].kind;
                    item_bus.value <= pending_ops[0].value;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                result_bus.ready <= 1'b0;
            end
            else if (!holdoff_done && words_seen >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= !take_idle();
            end
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int                 random_count;
        int                 seg_len;
        int                 roll;
        logic               push_heavy;
        kind_t              rand_kind;
        logic signed [31:0] rand_value;

        item_bus.valid   = 1'b0;
        item_bus.kind    = KIND_PUSH;
        item_bus.value   = '0;
        result_bus.ready = 1'b0;
        rst_n            = 1'b0;
        item_fire        = 1'b0;
        cycle_count      = 0;
        words_seen       = 0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        holdoff_left     = 0;
        holdoff_done     = 1'b0;
        held_count       = 0;
        random_count     = 0;

        // Empty-stack cases, then fill to the top with extremes and a duplicate.
        add_op(KIND_POP, $urandom);
        add_op(KIND_SEARCH, 32'sh0000_0000);
        add_op(KIND_DUMP, $urandom);
        add_op(KIND_PUSH, 32'sh7FFF_FFFF);
        add_op(KIND_PUSH, 32'sh8000_0000);
        add_op(KIND_PUSH, 32'sh0000_0000);
        add_op(KIND_PUSH, 32'shFFFF_FFFF);
        add_op(KIND_PUSH, 32'sh5555_5555);
        add_op(KIND_PUSH, 32'shAAAA_AAAA);
        add_op(KIND_PUSH, 32'sh0000_0000);
        add_op(KIND_PUSH, 32'sh1234_5678);
        add_op(KIND_PUSH, 32'sh0BAD_F00D);
        add_op(KIND_SEARCH, 32'sh0000_0000);
        add_op(KIND_SEARCH, 32'sh7FFF_FFFF);
        add_op(KIND_SEARCH, 32'sh0000_0001);
        add_op(KIND_DUMP, $urandom);
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            add_op(KIND_POP, $urandom);
        end
        add_op(KIND_POP, $urandom);

        while (random_count < RANDOM_OPS)
        begin
            seg_len    = $urandom_range(1, 12);
            push_heavy = $urandom_range(0, 1);
            repeat (seg_len)
            begin
                roll = $urandom_range(0, 99);
                if (push_heavy)
                begin
                    if (roll < 60)
                        rand_kind = KIND_PUSH;
                    else if (roll < 75)
                        rand_kind = KIND_POP;
                    else if (roll < 90)
                        rand_kind = KIND_SEARCH;
                    else
                        rand_kind = KIND_DUMP;
                end
                else
                begin
                    if (roll < 15)
                        rand_kind = KIND_PUSH;
                    else if (roll < 60)
                        rand_kind = KIND_POP;
                    else if (roll < 85)
                        rand_kind = KIND_SEARCH;
                    else
                        rand_kind = KIND_DUMP;
                end
                if ($urandom_range(0, 1))
                    rand_value = $urandom;
                else
                    rand_value = 32'($urandom_range(0, 7)) - 32'sd4;
                add_op(rand_kind, rand_value);
                random_count++;
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || expected_words.size() != 0 || item_bus.valid)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_words.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
